// ===== rtl/core/satc_pkg.sv =====
package satc_pkg;

   // Field widths of the two channels and the configuration port
   localparam int ADDRESS_W = 32;
   localparam int CNT_W     = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 5;

   // Per-way recency rank
   localparam int                RANK_W    = 4;
   localparam logic [RANK_W-1:0] RANK_TOP  = 4'd15;
   // Old rank of a way that was free or is being replaced: above every stored rank
   localparam logic [RANK_W:0]   RANK_NONE = 5'd16;

   // Register reset values
   localparam logic [4:0] CACHE_SIZE_RST = 5'd13;
   localparam logic [3:0] BLOCK_SIZE_RST = 4'd4;
   localparam logic [1:0] WAYS_RST       = 2'd2;
   localparam logic       FIFO_MODE_RST  = 1'b0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CACHE_SIZE = 2'd0,
      CSR_BLOCK_SIZE = 2'd1,
      CSR_WAYS       = 2'd2,
      CSR_FIFO_MODE  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   // Control from the lookup stage to the set update logic
   typedef struct packed {
      logic       fifo_mode;
      logic [4:0] ways_num;
   } upd_ctl_type;

endpackage

// ===== rtl/core/satc_channels.sv =====
interface satc_req_if import satc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ADDRESS_W-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink (input valid, input address, output ready);
endinterface

interface satc_rsp_if import satc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             hit;
   logic [CNT_W-1:0] access_count;
   logic [CNT_W-1:0] hit_count;

   modport source (output valid, output hit, output access_count, output hit_count,
                   input ready);
   modport sink (input valid, input hit, input access_count, input hit_count,
                 output ready);
endinterface

// ===== rtl/core/satc_ram.sv =====
module satc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/core/satc_set_update.sv =====
module satc_set_update import satc_pkg::*; #(
   parameter int TAG_W    = 32,
   parameter int MAX_WAYS = 8
) (
   input  upd_ctl_type                           ctl,
   input  logic [TAG_W-1:0]                      tag,
   input  logic [MAX_WAYS*(1+TAG_W+RANK_W)-1:0]  row_rd,
   output logic [MAX_WAYS*(1+TAG_W+RANK_W)-1:0]  row_wr,
   output logic                                  hit
);

   localparam int ENT_W = 1 + TAG_W + RANK_W;

   logic [MAX_WAYS-1:0] vld;
   logic [MAX_WAYS-1:0] in_use;
   logic [MAX_WAYS-1:0] match;
   logic [MAX_WAYS-1:0] free;
   logic [MAX_WAYS-1:0] is_max;
   logic [MAX_WAYS-1:0] match_oh;
   logic [MAX_WAYS-1:0] free_oh;
   logic [MAX_WAYS-1:0] keep_oh;
   logic [TAG_W-1:0]    tags  [MAX_WAYS];
   logic [RANK_W-1:0]   ranks [MAX_WAYS];
   logic [RANK_W-1:0]   hit_rank;
   logic [RANK_W:0]     old_rank;
   logic                any_free;
   logic                seen_match;
   logic                seen_free;

   // Unpack the set: rank in the low bits, then tag, valid on top
   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         vld[w]    = row_rd[w*ENT_W + ENT_W - 1];
         tags[w]   = row_rd[w*ENT_W + RANK_W +: TAG_W];
         ranks[w]  = row_rd[w*ENT_W +: RANK_W];
         in_use[w] = 5'(w) < ctl.ways_num;
         match[w]  = in_use[w] && vld[w] && (tags[w] == tag);
         free[w]   = in_use[w] && !vld[w];
      end
   end

   // Victim: highest rank, lowest way on a tie
   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         is_max[w] = in_use[w];
         for (int v = 0; v < MAX_WAYS; v++) begin
            if (in_use[v] && (v < w) && !(ranks[v] < ranks[w])) begin
               is_max[w] = 1'b0;
            end
            if (in_use[v] && (v > w) && (ranks[v] > ranks[w])) begin
               is_max[w] = 1'b0;
            end
         end
      end
   end

   // Lowest matching way and lowest free way
   always_comb begin
      seen_match = 1'b0;
      seen_free  = 1'b0;
      hit_rank   = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         match_oh[w] = match[w] && !seen_match;
         free_oh[w]  = free[w] && !seen_free;
         seen_match  = seen_match || match[w];
         seen_free   = seen_free || free[w];
         if (match_oh[w]) begin
            hit_rank = hit_rank | ranks[w];
         end
      end
   end

   assign hit      = |match;
   assign any_free = |free;
   assign keep_oh  = hit ? match_oh : (any_free ? free_oh : is_max);
   assign old_rank = hit ? {1'b0, hit_rank} : RANK_NONE;

   always_comb begin
      row_wr = row_rd;
      if (!(hit && ctl.fifo_mode)) begin
         for (int w = 0; w < MAX_WAYS; w++) begin
            if (keep_oh[w]) begin
               row_wr[w*ENT_W +: ENT_W] = {1'b1, tag, {RANK_W{1'b0}}};
            end else if (in_use[w] && vld[w] && ({1'b0, ranks[w]} < old_rank)
                         && (ranks[w] != RANK_TOP)) begin
               row_wr[w*ENT_W +: RANK_W] = ranks[w] + 1'b1;
            end
         end
      end
   end

endmodule

// ===== rtl/core/set_associative_cache_tag_store.sv =====
// Set-associative tag store with LRU or FIFO replacement.
//
// req_ch carries one byte address per beat; rsp_ch returns one beat per
// request with the hit flag and the saturating access and hit counts.
// Geometry and policy come from four registers on the csr_ port; the user must
// write them only while the block is idle, which the block does not enforce.
//
// Each set is one row of a single-port-write, registered-read RAM holding
// every way's valid bit, tag and rank. A request is accepted and its set
// row read; in the lookup state hit detection, victim choice and rank
// aging run and the row is written back while the result is registered,
// both waiting there while rsp_ch is stalled. Only one request is in
// flight at a time, so reads never overlap a write to the same set; a new
// request is accepted only after the read-modify-write of the set row.
//
// After reset the RAM is swept, one set per cycle, to clear the valid bits
// of all 2^MAX_SET_BITS sets (1024 by default); req_ch.ready is low meanwhile.
// A result waiting on a stalled rsp_ch does not block the next request
// beat; that request waits in the lookup stage until the output frees.
module set_associative_cache_tag_store import satc_pkg::*; #(
   parameter int ADDR_BITS    = 32,
   parameter int MAX_SET_BITS = 10,
   parameter int MAX_WAYS     = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   satc_req_if.sink             req_ch,
   satc_rsp_if.source           rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wr_data
);

   localparam int TAG_W    = (ADDR_BITS < ADDRESS_W) ? ADDR_BITS : ADDRESS_W;
   localparam int NUM_SETS = 1 << MAX_SET_BITS;
   localparam int IDX_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int ROW_W    = MAX_WAYS * (1 + TAG_W + RANK_W);
   localparam logic [IDX_W-1:0] LAST_SET = IDX_W'(NUM_SETS - 1);
   localparam logic [ADDRESS_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDRESS_W) ?
      {ADDRESS_W{1'b1}} : ADDRESS_W'((64'd1 << ADDR_BITS) - 64'd1);

   // Configuration registers
   logic [4:0] cache_size_ff, cache_size_in;
   logic [3:0] block_size_ff, block_size_in;
   logic [1:0] ways_ff, ways_in;
   logic       fifo_mode_ff, fifo_mode_in;

   state_type state_ff, state_in;

   logic [IDX_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [IDX_W-1:0] set_ff, set_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic [CNT_W-1:0] acc_cnt_ff, acc_cnt_in;
   logic [CNT_W-1:0] hit_cnt_ff, hit_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff, rsp_hit_in;

   logic signed [6:0]    set_bits_raw;
   logic [4:0]           set_bits;
   logic [ADDRESS_W-1:0] addr_m;
   logic [ADDRESS_W-1:0] set_full;
   logic [ADDRESS_W-1:0] tag_full;
   logic [ADDRESS_W-1:0] set_mask;
   logic [4:0]           ways_pow;

   logic             out_free;
   logic             req_fire;
   logic             upd_fire;
   logic             ram_wr_en;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic [ROW_W-1:0] ram_wr_data;
   logic [ROW_W-1:0] row_rd;
   logic [ROW_W-1:0] row_wr;
   logic             upd_hit;
   upd_ctl_type      upd_ctl;

   // ---------------------------------------------------------------------
   // Configuration
   always_comb begin
      cache_size_in = cache_size_ff;
      block_size_in = block_size_ff;
      ways_in       = ways_ff;
      fifo_mode_in  = fifo_mode_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_CACHE_SIZE: cache_size_in = csr_wr_data[4:0];
            CSR_BLOCK_SIZE: block_size_in = csr_wr_data[3:0];
            CSR_WAYS:       ways_in       = csr_wr_data[1:0];
            CSR_FIFO_MODE:  fifo_mode_in  = csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Address split
   assign set_bits_raw = $signed({2'b00, cache_size_ff}) - $signed({3'b000, block_size_ff})
                       - $signed({5'b00000, ways_ff});

   always_comb begin
      if (set_bits_raw < 0) begin
         set_bits = 5'd0;
      end else if (set_bits_raw > $signed(7'(MAX_SET_BITS))) begin
         set_bits = 5'(MAX_SET_BITS);
      end else begin
         set_bits = set_bits_raw[4:0];
      end
   end

   assign addr_m   = req_ch.address & ADDR_MASK;
   assign set_mask = ADDRESS_W'((33'd1 << set_bits) - 33'd1);
   assign set_full = (addr_m >> block_size_ff) & set_mask;
   assign tag_full = addr_m >> (6'(block_size_ff) + 6'(set_bits));
   assign set_in   = set_full[IDX_W-1:0];
   assign tag_in   = tag_full[TAG_W-1:0];

   // ---------------------------------------------------------------------
   // Sequencer
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == LAST_SET) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_ch.ready = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = set_ff;
      ram_wr_data  = row_wr;
      upd_fire     = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            ram_wr_data = '0;
         end
         ST_IDLE: begin
            req_ch.ready = 1'b1;
         end
         ST_LOOKUP: begin
            ram_wr_en = out_free;
            upd_fire  = out_free;
         end
         default: ;
      endcase
   end

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign ram_rd_en = req_fire;
   assign clr_cnt_in = (state_ff == ST_CLEAR) ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

   // ---------------------------------------------------------------------
   // Set storage and update
   satc_ram #(
      .WIDTH(ROW_W),
      .DEPTH(NUM_SETS)
   ) u_set_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (set_in),
      .rd_data (row_rd)
   );

   assign ways_pow          = 5'd1 << ways_ff;
   assign upd_ctl.ways_num  = (ways_pow > 5'(MAX_WAYS)) ? 5'(MAX_WAYS) : ways_pow;
   assign upd_ctl.fifo_mode = fifo_mode_ff;

   satc_set_update #(
      .TAG_W    (TAG_W),
      .MAX_WAYS (MAX_WAYS)
   ) u_set_update (
      .ctl    (upd_ctl),
      .tag    (tag_ff),
      .row_rd (row_rd),
      .row_wr (row_wr),
      .hit    (upd_hit)
   );

   // ---------------------------------------------------------------------
   // Counters and result register
   always_comb begin
      acc_cnt_in = acc_cnt_ff;
      hit_cnt_in = hit_cnt_ff;
      if (upd_fire) begin
         if (acc_cnt_ff != '1) begin
            acc_cnt_in = acc_cnt_ff + 1'b1;
         end
         if (upd_hit && (hit_cnt_ff != '1)) begin
            hit_cnt_in = hit_cnt_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      if (upd_fire) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = upd_hit;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.hit          = rsp_hit_ff;
   assign rsp_ch.access_count = acc_cnt_ff;
   assign rsp_ch.hit_count    = hit_cnt_ff;

   // ---------------------------------------------------------------------
   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cache_size_ff <= CACHE_SIZE_RST;
         block_size_ff <= BLOCK_SIZE_RST;
         ways_ff       <= WAYS_RST;
         fifo_mode_ff  <= FIFO_MODE_RST;
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         acc_cnt_ff    <= '0;
         hit_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cache_size_ff <= cache_size_in;
         block_size_ff <= block_size_in;
         ways_ff       <= ways_in;
         fifo_mode_ff  <= fifo_mode_in;
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         acc_cnt_ff    <= acc_cnt_in;
         hit_cnt_ff    <= hit_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Hold the lookup operands until the set is written back
   always_ff @(posedge clock) begin
      if (req_fire) begin
         set_ff <= set_in;
         tag_ff <= tag_in;
      end
      rsp_hit_ff <= rsp_hit_in;
   end

   // ---------------------------------------------------------------------
   // Assertions
   a_hits_within_accesses : assert property (@(posedge clock) disable iff (reset)
      hit_cnt_ff <= acc_cnt_ff)
      else $error("hit count exceeds access count");

   a_no_read_during_write : assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("set read overlaps a write-back");

   a_accept_enters_lookup : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_LOOKUP) && !req_ch.ready)
      else $error("request beat did not start a lookup");

   a_access_advances : assert property (@(posedge clock) disable iff (reset)
      (upd_fire && (acc_cnt_ff != '1)) |=> (acc_cnt_ff == $past(acc_cnt_ff) + 1'b1)
                                            && rsp_valid_ff)
      else $error("access count or result did not advance on write-back");

   a_hit_counted : assert property (@(posedge clock) disable iff (reset)
      (upd_fire && upd_hit && (hit_cnt_ff != '1)) |=> hit_cnt_ff == $past(hit_cnt_ff) + 1'b1)
      else $error("hit not counted");

endmodule
